>>> sv/bcc_pkg.sv
// Shared constants and types for the button click classifier.
// Field widths, register indexes, status bit positions and the lane timing config.
// No dependencies.
package bcc_pkg;

    localparam int PIN_W      = 10;
    localparam int TIME_W     = 16;
    localparam int CNT_W      = 16;
    localparam int BCOUNT_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int NUM_BUTTONS_DEF = 10;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd4;

    localparam int ST_SINGLE_BIT = 0;
    localparam int ST_DOUBLE_BIT = 1;
    localparam int ST_LONG_BIT   = 2;
    localparam int ST_W          = 3;

    typedef logic [ST_W-1:0] status_t;

    typedef struct packed {
        logic [CNT_W-1:0]  debounce_threshold;
        logic [TIME_W-1:0] double_click_timeout;
        logic [TIME_W-1:0] long_press_timeout;
    } lane_cfg_t;

    localparam lane_cfg_t LANE_CFG_RESET = '{
        debounce_threshold:   16'd3,
        double_click_timeout: 16'd300,
        long_press_timeout:   16'd1000
    };

endpackage

>>> sv/bcc_lane.sv
// One button lane: debounce, long-press and single/double click state machine.
// Holds the lane state and sticky status; advances once per transferred request.
// Depends on bcc_pkg.
module bcc_lane
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        run,
    input  logic                        clear,
    input  logic                        pressed,
    input  logic [bcc_pkg::TIME_W-1:0]  now_ms,
    input  bcc_pkg::lane_cfg_t          cfg,
    output bcc_pkg::status_t            status_next,
    output logic                        lane_event
);

    localparam logic [2:0] PH_UP1_IN = 3'd0;
    localparam logic [2:0] PH_UP1    = 3'd1;
    localparam logic [2:0] PH_DN1_IN = 3'd2;
    localparam logic [2:0] PH_DN1    = 3'd3;
    localparam logic [2:0] PH_UP2_IN = 3'd4;
    localparam logic [2:0] PH_UP2    = 3'd5;
    localparam logic [2:0] PH_DN2_IN = 3'd6;
    localparam logic [2:0] PH_DN2    = 3'd7;

    logic [2:0]                  phase_reg, phase_next;
    logic [bcc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [bcc_pkg::TIME_W-1:0]  start_reg, start_next;
    logic                        long_seen_reg, long_seen_next;
    bcc_pkg::status_t            status_reg;

    logic [bcc_pkg::TIME_W-1:0]  elapsed;
    logic                        long_expired;
    logic                        double_expired;
    logic                        bump_cond;
    logic [bcc_pkg::CNT_W-1:0]   count_bumped;
    logic                        settled;
    bcc_pkg::status_t            status_cleared;
    logic                        set_single;
    logic                        set_double;
    logic                        set_long;

    assign elapsed        = now_ms - start_reg;
    assign long_expired   = elapsed >= cfg.long_press_timeout;
    assign double_expired = elapsed >= cfg.double_click_timeout;
    assign bump_cond      = (phase_reg == PH_UP1 || phase_reg == PH_UP2) ? pressed : !pressed;
    assign settled        = count_bumped >= cfg.debounce_threshold;
    assign status_cleared = clear ? '0 : status_reg;

    always_comb
    begin
        if (!bump_cond)
        begin
            count_bumped = '0;
        end
        else if (count_reg == bcc_pkg::CNT_MAX)
        begin
            count_bumped = count_reg;
        end
        else
        begin
            count_bumped = count_reg + bcc_pkg::CNT_ONE;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        start_next     = start_reg;
        long_seen_next = long_seen_reg;
        set_single     = 1'b0;
        set_double     = 1'b0;
        set_long       = 1'b0;
        if (run)
        begin
            unique case (phase_reg)
                PH_UP1_IN:
                begin
                    count_next = '0;
                    phase_next = PH_UP1;
                end
                PH_UP1:
                begin
                    count_next = count_bumped;
                    if (settled)
                    begin
                        phase_next = PH_DN1_IN;
                    end
                end
                PH_DN1_IN:
                begin
                    start_next     = now_ms;
                    count_next     = '0;
                    long_seen_next = 1'b0;
                    phase_next     = PH_DN1;
                end
                PH_DN1:
                begin
                    if (!long_seen_reg && long_expired)
                    begin
                        long_seen_next = 1'b1;
                        set_long       = 1'b1;
                    end
                    count_next = count_bumped;
                    if (settled)
                    begin
                        if (long_seen_next)
                        begin
                            phase_next = PH_UP1_IN;
                        end
                        else if (double_expired)
                        begin
                            set_single = 1'b1;
                            phase_next = PH_UP1_IN;
                        end
                        else
                        begin
                            phase_next = PH_UP2_IN;
                        end
                    end
                end
                PH_UP2_IN:
                begin
                    start_next = now_ms;
                    count_next = '0;
                    phase_next = PH_UP2;
                end
                PH_UP2:
                begin
                    if (double_expired)
                    begin
                        set_single = 1'b1;
                        phase_next = PH_UP1_IN;
                    end
                    count_next = count_bumped;
                    // a debounced press wins the phase over the window expiry, but the single flag is still set
                    if (settled)
                    begin
                        phase_next = PH_DN2_IN;
                    end
                end
                PH_DN2_IN:
                begin
                    start_next = now_ms;
                    count_next = '0;
                    phase_next = PH_DN2;
                end
                PH_DN2:
                begin
                    count_next = count_bumped;
                    if (settled)
                    begin
                        set_double = 1'b1;
                        phase_next = PH_UP1_IN;
                    end
                end
                default:
                begin
                    phase_next = PH_UP1_IN;
                end
            endcase
        end
    end

    always_comb
    begin
        status_next = status_cleared;
        status_next[bcc_pkg::ST_SINGLE_BIT] = status_cleared[bcc_pkg::ST_SINGLE_BIT] | set_single;
        status_next[bcc_pkg::ST_DOUBLE_BIT] = status_cleared[bcc_pkg::ST_DOUBLE_BIT] | set_double;
        status_next[bcc_pkg::ST_LONG_BIT]   = status_cleared[bcc_pkg::ST_LONG_BIT]   | set_long;
    end

    assign lane_event = set_single | set_double | set_long;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_UP1_IN;
            count_reg     <= '0;
            start_reg     <= '0;
            long_seen_reg <= 1'b0;
            status_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            long_seen_reg <= long_seen_next;
            status_reg    <= status_next;
        end
    end

endmodule

>>> sv/button_click_classifier.sv
// Top level of the button click classifier: stream ports, config registers, lanes.
// Instantiates bcc_lane once per button; depends on bcc_pkg.
//
// One request per service tick enters on the s_ stream and yields exactly one result on the
// m_ stream: a request is held in an input register, every lane evaluates its state machine
// in a single pass, and the flags and event mask land in a result register. The block
// sustains one request per clock cycle while results are taken, set by that single-pass lane
// update; while a result is stalled, one further request can still enter the input register,
// and later requests wait until the result is taken.
// Configuration writes are taken at any time on the cfg_ channel and should be issued while
// no request is in flight.
module button_click_classifier
#(
    parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [9:0] pin_levels, [25:10] now_ms, [35:26] clear_mask, [39:36] zero
    input  logic [bcc_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] tick
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] single_flags, [19:10] double_flags, [29:20] long_flags, [39:30] event_mask
    output logic [bcc_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PW = bcc_pkg::PIN_W;
    localparam int TW = bcc_pkg::TIME_W;

    logic [bcc_pkg::BCOUNT_W-1:0] button_count_reg;
    logic [PW-1:0]                polarity_reg;
    bcc_pkg::lane_cfg_t           lane_cfg_reg;

    logic                         in_valid_reg;
    logic                         in_tick_reg;
    logic [PW-1:0]                in_pins_reg;
    logic [TW-1:0]                in_now_reg;
    logic [PW-1:0]                in_clear_reg;

    logic                         out_valid_reg;
    logic [PW-1:0]                out_single_reg;
    logic [PW-1:0]                out_double_reg;
    logic [PW-1:0]                out_long_reg;
    logic [PW-1:0]                out_event_reg;

    logic                         advance;
    logic                         in_load;

    logic [NUM_BUTTONS-1:0]       lane_run;
    logic [NUM_BUTTONS-1:0]       lane_clear;
    logic [NUM_BUTTONS-1:0]       lane_pressed;
    logic [NUM_BUTTONS-1:0]       lane_event;
    bcc_pkg::status_t             lane_status [NUM_BUTTONS];

    logic [PW-1:0]                single_next;
    logic [PW-1:0]                double_next;
    logic [PW-1:0]                long_next;
    logic [PW-1:0]                event_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_load   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_event_reg, out_long_reg, out_double_reg, out_single_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg <= '0;
            polarity_reg     <= '0;
            lane_cfg_reg     <= bcc_pkg::LANE_CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bcc_pkg::REG_BUTTON_COUNT:
                    button_count_reg <= cfg_data[bcc_pkg::BCOUNT_W-1:0];
                bcc_pkg::REG_POLARITY:
                    polarity_reg <= cfg_data[PW-1:0];
                bcc_pkg::REG_DEBOUNCE:
                    lane_cfg_reg.debounce_threshold <= cfg_data[bcc_pkg::CNT_W-1:0];
                bcc_pkg::REG_DOUBLE_CLICK:
                    lane_cfg_reg.double_click_timeout <= cfg_data[TW-1:0];
                bcc_pkg::REG_LONG_PRESS:
                    lane_cfg_reg.long_press_timeout <= cfg_data[TW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_tick_reg  <= s_tuser;
            in_pins_reg  <= s_tdata[PW-1:0];
            in_now_reg   <= s_tdata[PW+TW-1:PW];
            in_clear_reg <= s_tdata[2*PW+TW-1:PW+TW];
        end
    end

    genvar i;
    generate
        for (i = 0; i < NUM_BUTTONS; i++)
        begin : g_lane
            if (i < PW)
            begin : g_pin
                assign lane_pressed[i] = in_pins_reg[i] == polarity_reg[i];
                assign lane_clear[i]   = in_clear_reg[i];
            end
            else
            begin : g_nopin
                // lanes past the pin field see level 0 against polarity 0
                assign lane_pressed[i] = 1'b1;
                assign lane_clear[i]   = 1'b0;
            end

            assign lane_run[i] = in_tick_reg && (int'(button_count_reg) > i);

            bcc_lane u_lane
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .advance     (advance),
                .run         (lane_run[i]),
                .clear       (lane_clear[i]),
                .pressed     (lane_pressed[i]),
                .now_ms      (in_now_reg),
                .cfg         (lane_cfg_reg),
                .status_next (lane_status[i]),
                .lane_event  (lane_event[i])
            );
        end

        for (i = 0; i < PW; i++)
        begin : g_field
            if (i < NUM_BUTTONS)
            begin : g_used
                assign single_next[i] = lane_status[i][bcc_pkg::ST_SINGLE_BIT];
                assign double_next[i] = lane_status[i][bcc_pkg::ST_DOUBLE_BIT];
                assign long_next[i]   = lane_status[i][bcc_pkg::ST_LONG_BIT];
                assign event_next[i]  = lane_event[i];
            end
            else
            begin : g_unused
                assign single_next[i] = 1'b0;
                assign double_next[i] = 1'b0;
                assign long_next[i]   = 1'b0;
                assign event_next[i]  = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_single_reg <= single_next;
            out_double_reg <= double_next;
            out_long_reg   <= long_next;
            out_event_reg  <= event_next;
        end
    end

    a_event_has_flag : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        ((out_event_reg & ~(out_single_reg | out_double_reg | out_long_reg)) == '0))
    else $error("event raised without a matching status flag");

    a_idle_no_event : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_tick_reg) |=> (out_event_reg == '0))
    else $error("event raised on a non-tick request");

    a_idle_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_tick_reg) |=>
        (((out_single_reg | out_double_reg | out_long_reg) & $past(in_clear_reg)) == '0))
    else $error("cleared flags survived a non-tick request");

endmodule
